// ===== rtl/fpau_pkg.sv =====
`timescale 1ns / 1ps

package fpau_pkg;

  localparam int DATA_W   = 32;
  localparam int NUM_W    = 2 * DATA_W;
  localparam int DIV_STEPS = NUM_W;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] RND_ZERO  = 2'd0;
  localparam logic [1:0] RND_EVEN  = 2'd1;
  localparam logic [1:0] RND_UP    = 2'd2;
  localparam logic [1:0] RND_DOWN  = 2'd3;

  localparam logic [1:0] REG_INT_BITS      = 2'd0;
  localparam logic [1:0] REG_FRAC_BITS     = 2'd1;
  localparam logic [1:0] REG_ROUNDING_MODE = 2'd2;

  typedef enum logic [1:0] {
    PATH_DIRECT,
    PATH_MUL,
    PATH_DIV
  } path_t;

  typedef struct packed {
    path_t              path;
    logic               flag;
    logic               neg;
    logic [1:0]         mode;
    logic [5:0]         f;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  res_d;
    logic [NUM_W-1:0]   n;
    logic [DATA_W-1:0]  r;
    logic [DATA_W-1:0]  q;
    logic [DATA_W-1:0]  mb;
  } stage_t;

endpackage

// ===== rtl/fpau_div_step.sv =====
`timescale 1ns / 1ps

module fpau_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  fpau_pkg::stage_t in_stage,
  output logic            out_valid,
  output fpau_pkg::stage_t out_stage
);
  import fpau_pkg::*;

  logic [DATA_W:0] r2;
  logic            take;
  stage_t          stage_next;

  // one restoring quotient bit per stage; other paths pass through
  always_comb begin
    stage_next = in_stage;
    r2   = {in_stage.r, in_stage.n[NUM_W-1]};
    take = (r2 >= {1'b0, in_stage.mb});
    if (in_stage.path == PATH_DIV) begin
      stage_next.r = take ? DATA_W'(r2 - {1'b0, in_stage.mb}) : r2[DATA_W-1:0];
      stage_next.n = {in_stage.n[NUM_W-2:0], 1'b0};
      stage_next.q = {in_stage.q[DATA_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== rtl/fixed_point_arith_unit.sv =====
`timescale 1ns / 1ps
// channel  | dir | handshake                 | payload
// s_*      | in  | s_tvalid / s_tready       | s_tdata: command, operand_a, operand_b
// m_*      | out | m_tvalid / m_tready       | m_tdata: result_value; m_tuser: div_by_zero
// cfg_*    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One request enters per cycle unless the output stalls; from acceptance to a valid
// result it passes input, operand prep, multiply, 64 divider bit stages, rounding prep
// and the output register. The divider's one-bit-per-stage chain sets the depth.
// Reset is synchronous: it empties the pipeline and loads 16 / 16 / toward zero.
// A stall on the output freezes every stage at once; nothing drops or repeats.
module fixed_point_arith_unit #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // command[1:0], operand_a[33:2], operand_b[65:34], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[31:0]
  output logic        m_tuser,   // div_by_zero[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import fpau_pkg::*;

  // configuration registers
  logic [5:0] int_bits;
  logic [5:0] frac_bits;
  logic [1:0] rounding_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_bits      <= 6'd16;
      frac_bits     <= 6'd16;
      rounding_mode <= RND_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INT_BITS:      int_bits      <= cfg_data;
        REG_FRAC_BITS:     frac_bits     <= cfg_data;
        REG_ROUNDING_MODE: rounding_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the output holds a stalled result
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: capture request and format
  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [DATA_W-1:0] s1_a;
  logic [DATA_W-1:0] s1_b;
  logic [5:0]        s1_int;
  logic [5:0]        s1_frac;
  logic [1:0]        s1_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= s_tdata[1:0];
      s1_a    <= s_tdata[33:2];
      s1_b    <= s_tdata[65:34];
      s1_int  <= int_bits;
      s1_frac <= frac_bits;
      s1_mode <= rounding_mode;
    end
  end

  // stage 2: mask operands, take magnitudes, finish add and subtract
  logic [6:0]        w;
  logic [6:0]        sh;
  logic              w_ok;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] sign_bit;
  logic [DATA_W-1:0] am;
  logic [DATA_W-1:0] bm;
  logic              na;
  logic              nb;
  stage_t            s2_next;
  stage_t            s2;
  logic              s2_valid;

  always_comb begin
    w        = {1'b0, s1_int} + {1'b0, s1_frac};
    w_ok     = (w != 7'd0) && (w <= 7'(MAX_WIDTH));
    sh       = 7'd32 - w;
    mask     = w_ok ? ({DATA_W{1'b1}} >> sh[5:0]) : '0;
    sign_bit = mask & ~(mask >> 1);
    am       = s1_a & mask;
    bm       = s1_b & mask;
    na       = |(am & sign_bit);
    nb       = |(bm & sign_bit);

    s2_next       = '0;
    s2_next.path  = PATH_DIRECT;
    s2_next.neg   = na ^ nb;
    s2_next.mode  = s1_mode;
    s2_next.f     = s1_frac;
    s2_next.mask  = mask;
    s2_next.n     = {{DATA_W{1'b0}}, (na ? ((~am + 1'b1) & mask) : am)};
    s2_next.mb    = nb ? ((~bm + 1'b1) & mask) : bm;
    if (w_ok) begin
      case (s1_cmd)
        CMD_ADD: s2_next.res_d = (am + bm) & mask;
        CMD_SUB: s2_next.res_d = (am - bm) & mask;
        CMD_MUL: s2_next.path  = PATH_MUL;
        CMD_DIV: begin
          if (bm == '0) begin
            s2_next.flag = 1'b1;
          end else begin
            s2_next.path = PATH_DIV;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

  // stage 3: multiply, or align the dividend
  stage_t s3_next;
  stage_t st [0:DIV_STEPS];
  logic   st_valid [0:DIV_STEPS];

  always_comb begin
    s3_next   = s2;
    s3_next.r = '0;
    s3_next.q = '0;
    case (s2.path)
      PATH_MUL: s3_next.n = s2.n[DATA_W-1:0] * s2.mb;
      PATH_DIV: s3_next.n = s2.n << s2.f;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= s3_next;
    end
  end

  // divider bit stages
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    fpau_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (st_valid[k]),
      .in_stage  (st[k]),
      .out_valid (st_valid[k+1]),
      .out_stage (st[k+1])
    );
  end

  // rounding prep: pick quotient, remainder and divisor per path
  stage_t            last;
  logic [NUM_W-1:0]  p_shift;
  logic [NUM_W-1:0]  p_rmask;
  logic              fin_valid;
  path_t             fin_path;
  logic              fin_flag;
  logic              fin_neg;
  logic [1:0]        fin_mode;
  logic [DATA_W-1:0] fin_mask;
  logic [DATA_W-1:0] fin_res_d;
  logic [DATA_W-1:0] fin_q;
  logic [DATA_W-1:0] fin_rem;
  logic [DATA_W:0]   fin_dv;

  assign last    = st[DIV_STEPS];
  assign p_shift = last.n >> last.f;
  assign p_rmask = (NUM_W'(1) << last.f) - NUM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= st_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_path  <= last.path;
      fin_flag  <= last.flag;
      fin_neg   <= last.neg;
      fin_mode  <= last.mode;
      fin_mask  <= last.mask;
      fin_res_d <= last.res_d;
      if (last.path == PATH_MUL) begin
        fin_q   <= p_shift[DATA_W-1:0];
        fin_rem <= DATA_W'(last.n & p_rmask);
        fin_dv  <= (DATA_W+1)'(1) << last.f;
      end else begin
        fin_q   <= last.q;
        fin_rem <= last.r;
        fin_dv  <= {1'b0, last.mb};
      end
    end
  end

  // output stage: round the magnitude, wrap, apply sign
  logic [DATA_W-1:0] q_up;
  logic [DATA_W:0]   rem2;
  logic              rem_nz;
  logic [DATA_W-1:0] q_rnd;
  logic [DATA_W-1:0] q_wrap;
  logic [DATA_W-1:0] res_next;
  logic [DATA_W-1:0] out_mask;

  always_comb begin
    q_up   = fin_q + 1'b1;
    rem2   = {fin_rem, 1'b0};
    rem_nz = (fin_rem != '0);
    case (fin_mode)
      RND_EVEN: begin
        if (rem2 < fin_dv) begin
          q_rnd = fin_q;
        end else if (rem2 > fin_dv) begin
          q_rnd = q_up;
        end else begin
          q_rnd = fin_q[0] ? q_up : fin_q;
        end
      end
      RND_UP:   q_rnd = (!fin_neg && rem_nz) ? q_up : fin_q;
      RND_DOWN: q_rnd = (fin_neg && rem_nz) ? q_up : fin_q;
      default:  q_rnd = fin_q;
    endcase
    q_wrap = q_rnd & fin_mask;
    if (fin_path == PATH_DIRECT) begin
      res_next = fin_res_d;
    end else begin
      res_next = fin_neg ? ((~q_wrap + 1'b1) & fin_mask) : q_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata  <= res_next;
      m_tuser  <= fin_flag;
      out_mask <= fin_mask;
    end
  end

  // checks
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("divide-by-zero result not zero");

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata & ~out_mask) == '0)
    else $error("result bits above format width set");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    st_valid[DIV_STEPS] && last.path == PATH_DIV |-> last.r < last.mb)
    else $error("divider remainder not below divisor");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> s1_valid)
    else $error("accepted request did not enter pipeline");

endmodule

// ===== bench/fixed_point_arith_unit_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_arith_unit_tb;
  import fpau_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        dz;
  } fx_result_t;

  // one directed request: format, rounding, command, operands and, where it
  // is obvious, the typed-in answer
  typedef struct {
    logic [5:0]  ib;
    logic [5:0]  fb;
    logic [1:0]  mode;
    logic [1:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic [31:0] value;
    logic        dz;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;    // command[1:0], operand_a[33:2], operand_b[65:34], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // result_value[31:0]
  logic        m_tuser;    // div_by_zero[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  fixed_point_arith_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // local copy of the format registers, reset values of the block
  logic [5:0] fmt_int  = 6'd16;
  logic [5:0] fmt_frac = 6'd16;
  logic [1:0] fmt_mode = RND_ZERO;

  fx_result_t pending_results[$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         sent_items   = 0;
  int         cmd_count[4] = '{0, 0, 0, 0};
  int         dz_seen      = 0;
  int         formats_used = 0;
  int         burst_left   = 0;
  int         rx_cycle     = 0;

  vector_t directed[24];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("** fixed_point_arith_unit: FAILED **");
    $finish;
  end

  // Round the magnitude by the current mode; rem/div is the discarded fraction.
  function automatic logic [63:0] round_magnitude(logic [63:0] q, logic [63:0] rem,
                                                  logic [63:0] div, bit neg);
    case (fmt_mode)
      RND_EVEN: begin
        if (rem * 2 < div) return q;
        if (rem * 2 > div) return q + 1;
        return q + q[0];
      end
      RND_UP:   return (!neg && rem != 0) ? q + 1 : q;
      RND_DOWN: return (neg && rem != 0) ? q + 1 : q;
      default:  return q;
    endcase
  endfunction

  function automatic fx_result_t compute_fixed(logic [1:0] cmd, logic [31:0] a_in,
                                               logic [31:0] b_in);
    logic [6:0]  w;
    logic [63:0] mask, sign, a, b, ma, mb, q, rem, div, p, res;
    bit          neg;
    fx_result_t  r;
    w = {1'b0, fmt_int} + {1'b0, fmt_frac};
    r = '0;
    if (w == 0 || w > 32) return r;
    mask = (64'd1 << w) - 1;
    sign = 64'd1 << (w - 1);
    a    = {32'd0, a_in} & mask;
    b    = {32'd0, b_in} & mask;
    case (cmd)
      CMD_ADD: res = (a + b) & mask;
      CMD_SUB: res = (a - b) & mask;
      default: begin
        if (cmd == CMD_DIV && b == 0) begin
          r.dz = 1'b1;
          return r;
        end
        neg = ((a & sign) != 0) != ((b & sign) != 0);
        ma  = ((a & sign) != 0) ? (mask + 1) - a : a;
        mb  = ((b & sign) != 0) ? (mask + 1) - b : b;
        if (cmd == CMD_MUL) begin
          p   = ma * mb;
          div = 64'd1 << fmt_frac;
          q   = p >> fmt_frac;
          rem = p & (div - 1);
        end else begin
          p   = ma << fmt_frac;
          div = mb;
          q   = p / mb;
          rem = p % mb;
        end
        q   = round_magnitude(q, rem, div, neg) & mask;
        res = neg ? ((64'd0 - q) & mask) : q;
      end
    endcase
    r.value = res[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Receiver: cycle through always-ready, light random, periodic and heavy stalls.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 600) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ((rx_cycle % 7) < 3);
      default: m_tready <= $urandom_range(0, 1);
    endcase
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    fx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("[%0t] result %h with nothing expected", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.value) report_mismatch("result_value", m_tdata, want.value);
        if (m_tuser !== want.dz) report_mismatch("div_by_zero", m_tuser, want.dz);
      end
    end
  end

  // Drain the pipeline, then write all three registers.
  task automatic set_format(logic [5:0] ib, logic [5:0] fb, logic [1:0] mode);
    logic [5:0] vals[3];
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (72) @(posedge clk);
    vals = '{ib, fb, {4'd0, mode}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? REG_INT_BITS : (i == 1) ? REG_FRAC_BITS : REG_ROUNDING_MODE;
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    fmt_int  = ib;
    fmt_frac = fb;
    fmt_mode = mode;
    formats_used++;
  endtask

  // Present one request and hold it until accepted; queue its answer.
  task automatic send_request(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
                              bit typed, fx_result_t typed_res);
    fx_result_t exp_res;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, b, a, cmd};
    do @(posedge clk); while (!s_tready);
    exp_res = typed ? typed_res : compute_fixed(cmd, a, b);
    pending_results.insert(pending_results.size(), exp_res);
    sent_items++;
    cmd_count[cmd]++;
    if (cmd == CMD_DIV && exp_res.dz) dz_seen++;
  endtask

  // Sender pacing: bursts of random length with random gaps in between.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Operands: random words some of the time, otherwise format extremes and small values.
  function automatic logic [31:0] pick_operand();
    logic [6:0]  w;
    logic [31:0] upper;
    w = {1'b0, fmt_int} + {1'b0, fmt_frac};
    if (w == 0 || w > 32) w = 32;
    upper = $urandom();
    upper = (w == 32) ? 32'd0 : (upper & ~((32'd1 << w) - 1));
    case ($urandom_range(0, 7))
      0:       return upper | (32'd1 << (w - 1));
      1:       return upper | ((w == 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 1);
      2:       return upper;
      3:       return upper | $urandom_range(1, 7);
      4:       return upper | (32'd1 << fmt_frac[4:0]);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    fx_result_t tr;
    logic [6:0] w;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_INT_BITS;
    cfg_data  <= '0;

    // Directed table: reset format first, then small formats per rounding mode,
    // then illegal and edge widths.
    directed = '{
      '{16, 16, RND_ZERO, CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1, 32'h8000_0000, 0},
      '{16, 16, RND_ZERO, CMD_SUB, 32'h0000_0000, 32'h0000_0001, 1, 32'hFFFF_FFFF, 0},
      '{16, 16, RND_ZERO, CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0},
      '{16, 16, RND_ZERO, CMD_MUL, 32'h0001_0000, 32'h0001_0000, 1, 32'h0001_0000, 0},
      '{16, 16, RND_ZERO, CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
      '{16, 16, RND_ZERO, CMD_MUL, 32'hFFFF_0000, 32'h0002_0000, 0, 0, 0},
      '{16, 16, RND_ZERO, CMD_DIV, 32'h0000_0005, 32'h0000_0000, 1, 32'h0000_0000, 1},
      '{16, 16, RND_ZERO, CMD_DIV, 32'h0003_0000, 32'h0002_0000, 0, 0, 0},
      '{16, 16, RND_ZERO, CMD_DIV, 32'h8000_0000, 32'hFFFF_0000, 0, 0, 0},
      '{4, 4, RND_ZERO, CMD_ADD, 32'hFFFF_FF01, 32'h0000_0001, 1, 32'h0000_0002, 0},
      '{4, 4, RND_EVEN, CMD_MUL, 32'h18, 32'h18, 0, 0, 0},
      '{4, 4, RND_EVEN, CMD_MUL, 32'h01, 32'h08, 0, 0, 0},
      '{4, 4, RND_EVEN, CMD_DIV, 32'h01, 32'h30, 0, 0, 0},
      '{4, 4, RND_UP, CMD_MUL, 32'h01, 32'h01, 0, 0, 0},
      '{4, 4, RND_UP, CMD_MUL, 32'hFF, 32'h01, 0, 0, 0},
      '{4, 4, RND_DOWN, CMD_MUL, 32'hFF, 32'h01, 0, 0, 0},
      '{4, 4, RND_DOWN, CMD_DIV, 32'h10, 32'hD0, 0, 0, 0},
      '{40, 0, RND_ZERO, CMD_ADD, 32'h1, 32'h2, 1, 32'h0, 0},
      '{0, 0, RND_ZERO, CMD_DIV, 32'h1, 32'h0, 1, 32'h0, 0},
      '{63, 63, RND_DOWN, CMD_SUB, 32'h5, 32'h9, 1, 32'h0, 0},
      '{0, 1, RND_EVEN, CMD_MUL, 32'h1, 32'h1, 0, 0, 0},
      '{1, 0, RND_ZERO, CMD_SUB, 32'h0, 32'h1, 0, 0, 0},
      '{0, 32, RND_UP, CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0},
      '{32, 0, RND_DOWN, CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0}
    };

    // Hold reset, once only, then release it.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table; reformat only when a row asks for a new format.
    foreach (directed[i]) begin
      if (directed[i].ib != fmt_int || directed[i].fb != fmt_frac ||
          directed[i].mode != fmt_mode)
        set_format(directed[i].ib, directed[i].fb, directed[i].mode);
      tr.value = directed[i].value;
      tr.dz    = directed[i].dz;
      send_request(directed[i].cmd, directed[i].a, directed[i].b, directed[i].typed, tr);
      pace_sender();
    end

    // Random phases: mostly legal formats, now and then an illegal one.
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 0) begin
        set_format(6'd32, 6'd0, RND_EVEN);
      end else if (ph == 1) begin
        set_format(6'd0, 6'd32, RND_DOWN);
      end else if (ph == 2) begin
        set_format(6'd63, 6'd0, RND_UP);
      end else if ($urandom_range(0, 7) == 0) begin
        set_format(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   2'($urandom_range(0, 3)));
      end else begin
        w = 7'($urandom_range(1, 32));
        tr.value = $urandom_range(0, w);
        set_format(6'(w - {1'b0, tr.value[5:0]}), tr.value[5:0],
                   2'($urandom_range(0, 3)));
      end
      for (int k = 0; k < 59; k++) begin
        // Pause once mid-phase until the pipeline is empty.
        if (ph == 5 && k == 30) begin
          s_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_request(2'($urandom_range(0, 3)), pick_operand(), pick_operand(), 0, '0);
        pace_sender();
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then let the full pipeline depth pass for any stray output.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d requests (add %0d, sub %0d, mul %0d, div %0d) over %0d formats.",
             sent_items, cmd_count[CMD_ADD], cmd_count[CMD_SUB], cmd_count[CMD_MUL],
             cmd_count[CMD_DIV], formats_used);
    $display("Checked %0d results, %0d zero-divisor flags, %0d mismatches.",
             results_seen, dz_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** fixed_point_arith_unit: PASSED **");
    end else begin
      $display("** fixed_point_arith_unit: FAILED **");
    end
    $finish;
  end

endmodule
